FILE: rtl/core/plex_pkg.sv
package plex_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int KEYWORD_COUNT = 32;
  localparam int KW_SLOT = 10;

  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  literal_char;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_IDENT   = 10'b0000000010,
    M_NUMBER  = 10'b0000000100,
    M_STRING  = 10'b0000001000,
    M_CHVAL   = 10'b0000010000,
    M_CHCLOSE = 10'b0000100000,
    M_LESS    = 10'b0001000000,
    M_GREATER = 10'b0010000000,
    M_BANG    = 10'b0100000000,
    M_MINUS   = 10'b1000000000
  } mode_t;

  localparam logic [5:0] K_CHARLIT = 6'd22;
  localparam logic [5:0] K_IDENT   = 6'd32;
  localparam logic [5:0] K_NUMBER  = 6'd33;
  localparam logic [5:0] K_STRING  = 6'd34;
  localparam logic [5:0] K_LE      = 6'd35;
  localparam logic [5:0] K_ASSIGN  = 6'd36;
  localparam logic [5:0] K_LT      = 6'd37;
  localparam logic [5:0] K_GE      = 6'd38;
  localparam logic [5:0] K_GT      = 6'd39;
  localparam logic [5:0] K_NE      = 6'd40;
  localparam logic [5:0] K_BANG    = 6'd41;
  localparam logic [5:0] K_ARROW   = 6'd42;
  localparam logic [5:0] K_MINUS   = 6'd43;
  localparam logic [5:0] K_PLUS    = 6'd44;
  localparam logic [5:0] K_STAR    = 6'd45;
  localparam logic [5:0] K_SLASH   = 6'd46;
  localparam logic [5:0] K_EQ      = 6'd47;
  localparam logic [5:0] K_DOT     = 6'd48;
  localparam logic [5:0] K_COMMA   = 6'd49;
  localparam logic [5:0] K_SEMI    = 6'd50;
  localparam logic [5:0] K_LPAR    = 6'd51;
  localparam logic [5:0] K_RPAR    = 6'd52;
  localparam logic [5:0] K_LBRK    = 6'd53;
  localparam logic [5:0] K_RBRK    = 6'd54;
  localparam logic [5:0] K_EOF     = 6'd55;
  localparam logic [5:0] K_ERR_STR = 6'd56;
  localparam logic [5:0] K_ERR_CHR = 6'd57;
  localparam logic [5:0] K_ERR_UNX = 6'd58;

  typedef logic [KW_SLOT*8-1:0] kw_text_t;

  // keyword text, byte 0 in the low bits, zero padded
  function automatic kw_text_t kw_text(input int k);
    string s;
    kw_text_t t;
    case (k)
      0: s = "debfonc";   1: s = "finfonc";   2: s = "faire";     3: s = "finfaire";
      4: s = "si";        5: s = "alors";     6: s = "sinon";     7: s = "finsi";
      8: s = "tantque";   9: s = "pour";      10: s = "haut";     11: s = "bas";
      12: s = "et";       13: s = "ou";       14: s = "non";      15: s = "div";
      16: s = "mod";      17: s = "retourner"; 18: s = "structure"; 19: s = "type";
      20: s = "vide";     21: s = "chaine";   22: s = "caractere"; 23: s = "entier";
      24: s = "reel";     25: s = "booleen";  26: s = "vrai";     27: s = "faux";
      28: s = "nil";      29: s = "d";        30: s = "r";        31: s = "dr";
      default: s = "";
    endcase
    t = '0;
    for (int i = 0; i < s.len(); i++) begin
      t[i*8 +: 8] = s[i];
    end
    return t;
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h2B: return K_PLUS;
      8'h2A: return K_STAR;
      8'h2F: return K_SLASH;
      8'h3D: return K_EQ;
      8'h2E: return K_DOT;
      8'h2C: return K_COMMA;
      8'h3B: return K_SEMI;
      8'h28: return K_LPAR;
      8'h29: return K_RPAR;
      8'h5B: return K_LBRK;
      8'h5D: return K_RBRK;
      default: return K_ERR_UNX;
    endcase
  endfunction

endpackage

FILE: rtl/core/pseudocode_lexer.sv
// Streaming lexer for a small French pseudocode. One byte (or end of input) is taken
// per transfer, every cycle when the result side keeps up and no second token is
// waiting; each transfer yields zero, one or two tokens. A two-token transfer holds
// in_ready low while the second token waits behind the head. Keywords are found by
// a 32-bit candidate mask narrowed on each identifier byte.
module pseudocode_lexer #(
  parameter int COUNT_BITS = plex_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plex_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plex_pkg::out_item_t out_data
);

  localparam int CB = COUNT_BITS;
  localparam logic [CB-1:0] CMAX = '1;
  localparam logic [CB-1:0] ONE = CB'(1);

  plex_pkg::mode_t mode_r, mode_nxt;
  logic [CB-1:0] cl_r, cl_nxt, cc_r, cc_nxt, cp_r, cp_nxt;
  logic [CB-1:0] tl_r, tl_nxt, tc_r, tc_nxt, ts_r, ts_nxt, tn_r, tn_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [7:0] held_r, held_nxt;

  // two-entry output: head shown, second waiting
  plex_pkg::out_item_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic v0_r, v0_nxt, v1_r, v1_nxt;

  plex_pkg::out_item_t e0, e1;
  logic ne0, ne1;
  logic acc, pop;

  logic [7:0] c;
  logic fin, sp, al, dg;
  logic [31:0] km_in, km_out;
  logic [CB-1:0] km_len;
  logic [5:0] km_kind;

  function automatic logic [CB-1:0] sinc(input logic [CB-1:0] v);
    return (v == CMAX) ? v : v + ONE;
  endfunction

  function automatic logic [15:0] s16(input logic [CB-1:0] v);
    logic [CB+15:0] w;
    w = {16'd0, v};
    return (w > (CB+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic plex_pkg::out_item_t mk(input logic [5:0] k, input logic [CB-1:0] l,
      input logic [CB-1:0] col, input logic [CB-1:0] st, input logic [CB-1:0] ln,
      input logic [7:0] lit);
    plex_pkg::out_item_t r;
    r.token_kind = k;
    r.token_line = s16(l);
    r.token_column = s16(col);
    r.token_start = s16(st);
    r.token_length = s16(ln);
    r.literal_char = lit;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  plex_kwmatch #(.CB(CB)) u_kw (
    .mask_i(km_in), .len_i(km_len), .c_i(c), .narrowed_o(km_out), .kind_o(km_kind)
  );

  assign c   = in_data.char_byte;
  assign fin = in_data.action || (c == 8'd0);
  assign sp  = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  assign al  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign dg  = (c >= 8'h30 && c <= 8'h39);

  assign out_valid = v0_r;
  assign out_data  = q0_r;
  assign pop       = v0_r && out_ready;
  // free space once pop happens: accept only while no entry stays after pop
  assign in_ready  = !v1_r && (!v0_r || out_ready);
  assign acc       = in_valid && in_ready;

  always_comb begin
    logic done, idle_go, cons;
    mode_nxt = mode_r;
    cl_nxt = cl_r; cc_nxt = cc_r; cp_nxt = cp_r;
    tl_nxt = tl_r; tc_nxt = tc_r; ts_nxt = ts_r; tn_nxt = tn_r;
    mask_nxt = mask_r; held_nxt = held_r;
    e0 = '0; e1 = '0; ne0 = 1'b0; ne1 = 1'b0;
    done = 1'b0; cons = 1'b0;
    km_in = mask_r; km_len = tn_r;
    // outside an identifier the matcher serves a fresh token start
    if (mode_r != plex_pkg::M_IDENT) begin
      km_in = '1; km_len = '0;
    end
    case (mode_r)
      plex_pkg::M_IDENT: begin
        if (!fin && (al || dg || c == 8'h5F)) begin
          mask_nxt = km_out; tn_nxt = sinc(tn_r); cons = 1'b1; done = 1'b1;
        end else begin
          e0 = mk(km_kind, tl_r, tc_r, ts_r, tn_r, 8'd0); ne0 = 1'b1;
          mode_nxt = plex_pkg::M_IDLE;
        end
      end
      plex_pkg::M_NUMBER: begin
        if (!fin && dg) begin
          tn_nxt = sinc(tn_r); cons = 1'b1; done = 1'b1;
        end else begin
          e0 = mk(plex_pkg::K_NUMBER, tl_r, tc_r, ts_r, tn_r, 8'd0); ne0 = 1'b1;
          mode_nxt = plex_pkg::M_IDLE;
        end
      end
      plex_pkg::M_STRING: begin
        if (fin) begin
          e0 = mk(plex_pkg::K_ERR_STR, tl_r, tc_r, ts_r, tn_r, 8'd0); ne0 = 1'b1;
          mode_nxt = plex_pkg::M_IDLE;
        end else if (c == 8'h22) begin
          e0 = mk(plex_pkg::K_STRING, tl_r, tc_r, ts_r, tn_r, 8'd0); ne0 = 1'b1;
          cons = 1'b1; done = 1'b1; mode_nxt = plex_pkg::M_IDLE;
        end else begin
          tn_nxt = sinc(tn_r); cons = 1'b1; done = 1'b1;
        end
      end
      plex_pkg::M_CHVAL: begin
        if (fin) begin
          e0 = mk(plex_pkg::K_ERR_CHR, tl_r, tc_r, ts_r, '0, 8'd0); ne0 = 1'b1;
          mode_nxt = plex_pkg::M_IDLE;
        end else begin
          held_nxt = c; cons = 1'b1; done = 1'b1; mode_nxt = plex_pkg::M_CHCLOSE;
        end
      end
      plex_pkg::M_CHCLOSE: begin
        if (!fin && c == 8'h27) begin
          e0 = mk(plex_pkg::K_CHARLIT, tl_r, tc_r, ts_r, ONE, held_r);
          cons = 1'b1; done = 1'b1;
        end else begin
          e0 = mk(plex_pkg::K_ERR_CHR, tl_r, tc_r, ts_r, ONE, 8'd0);
        end
        ne0 = 1'b1; mode_nxt = plex_pkg::M_IDLE;
      end
      plex_pkg::M_LESS, plex_pkg::M_GREATER, plex_pkg::M_BANG, plex_pkg::M_MINUS: begin
        logic [7:0] sec;
        logic [5:0] kb, ks;
        sec = 8'h3D; kb = plex_pkg::K_LE; ks = plex_pkg::K_LT;
        case (mode_r)
          plex_pkg::M_GREATER: begin kb = plex_pkg::K_GE; ks = plex_pkg::K_GT; end
          plex_pkg::M_BANG: begin kb = plex_pkg::K_NE; ks = plex_pkg::K_BANG; end
          plex_pkg::M_MINUS: begin
            sec = 8'h3E; kb = plex_pkg::K_ARROW; ks = plex_pkg::K_MINUS;
          end
          default: ;
        endcase
        ne0 = 1'b1; mode_nxt = plex_pkg::M_IDLE;
        if (!fin && mode_r == plex_pkg::M_LESS && c == 8'h2D) begin
          e0 = mk(plex_pkg::K_ASSIGN, tl_r, tc_r, ts_r, CB'(2), 8'd0);
          cons = 1'b1; done = 1'b1;
        end else if (!fin && c == sec) begin
          e0 = mk(kb, tl_r, tc_r, ts_r, CB'(2), 8'd0); cons = 1'b1; done = 1'b1;
        end else begin
          e0 = mk(ks, tl_r, tc_r, ts_r, ONE, 8'd0);
        end
      end
      default: mode_nxt = plex_pkg::M_IDLE;
    endcase
    idle_go = !done;
    if (idle_go) begin
      plex_pkg::out_item_t ei;
      logic ni;
      ei = '0; ni = 1'b0;
      if (fin) begin
        ei = mk(plex_pkg::K_EOF, cl_r, cc_r, cp_r, '0, 8'd0); ni = 1'b1;
      end else begin
        cons = 1'b1;
        if (!sp) begin
          tl_nxt = cl_r; tc_nxt = cc_r; ts_nxt = cp_r; tn_nxt = '0;
          if (al || c == 8'h5F) begin
            mask_nxt = km_out; tn_nxt = ONE; mode_nxt = plex_pkg::M_IDENT;
          end else if (dg) begin
            tn_nxt = ONE; mode_nxt = plex_pkg::M_NUMBER;
          end else if (c == 8'h22) begin
            ts_nxt = sinc(cp_r); mode_nxt = plex_pkg::M_STRING;
          end else if (c == 8'h27) begin
            ts_nxt = sinc(cp_r); mode_nxt = plex_pkg::M_CHVAL;
          end else if (c == 8'h3C) begin
            mode_nxt = plex_pkg::M_LESS;
          end else if (c == 8'h3E) begin
            mode_nxt = plex_pkg::M_GREATER;
          end else if (c == 8'h21) begin
            mode_nxt = plex_pkg::M_BANG;
          end else if (c == 8'h2D) begin
            mode_nxt = plex_pkg::M_MINUS;
          end else begin
            ei = mk(plex_pkg::punct_kind(c), cl_r, cc_r, cp_r, ONE, 8'd0); ni = 1'b1;
          end
        end
      end
      if (ni) begin
        if (ne0) begin
          e1 = ei; ne1 = 1'b1;
        end else begin
          e0 = ei; ne0 = 1'b1;
        end
      end
    end
    if (cons) begin
      cp_nxt = sinc(cp_r);
      if (c == 8'h0A) begin
        cl_nxt = sinc(cl_r); cc_nxt = ONE;
      end else begin
        cc_nxt = sinc(cc_r);
      end
    end
    if (ne1) e1.last_of_run = 1'b1;
    else e0.last_of_run = 1'b1;
  end

  always_comb begin
    plex_pkg::out_item_t a0, a1;
    logic b0, b1;
    a0 = q0_r; a1 = q1_r; b0 = v0_r; b1 = v1_r;
    if (pop) begin
      a0 = q1_r; b0 = v1_r; b1 = 1'b0;
    end
    q0_nxt = a0; q1_nxt = a1; v0_nxt = b0; v1_nxt = b1;
    if (acc && ne0) begin
      if (!b0) begin
        q0_nxt = e0; v0_nxt = 1'b1;
        if (ne1) begin
          q1_nxt = e1; v1_nxt = 1'b1;
        end
      end else begin
        q1_nxt = e0; v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= plex_pkg::M_IDLE;
      cl_r <= ONE; cc_r <= ONE; cp_r <= '0;
      tl_r <= ONE; tc_r <= ONE; ts_r <= '0; tn_r <= '0;
      mask_r <= '1; held_r <= '0;
      v0_r <= 1'b0; v1_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt;
        cl_r <= cl_nxt; cc_r <= cc_nxt; cp_r <= cp_nxt;
        tl_r <= tl_nxt; tc_r <= tc_nxt; ts_r <= ts_nxt; tn_r <= tn_nxt;
        mask_r <= mask_nxt; held_r <= held_nxt;
      end
      v0_r <= v0_nxt; v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

FILE: rtl/core/plex_kwmatch.sv
module plex_kwmatch #(
  parameter int CB = plex_pkg::COUNT_BITS_DEF
) (
  input  logic [plex_pkg::KEYWORD_COUNT-1:0] mask_i,
  input  logic [CB-1:0]                      len_i,
  input  logic [7:0]                         c_i,
  output logic [plex_pkg::KEYWORD_COUNT-1:0] narrowed_o,
  output logic [5:0]                         kind_o
);

  localparam int KC = plex_pkg::KEYWORD_COUNT;
  localparam int KS = plex_pkg::KW_SLOT;

  logic [KC-1:0] endhit;
  logic          in_slot;
  logic [3:0]    idx;

  assign in_slot = len_i < CB'(KS);
  assign idx = in_slot ? 4'(len_i) : 4'd0;

  always_comb begin
    plex_pkg::kw_text_t txt;
    txt = '0;
    for (int k = 0; k < KC; k++) begin
      txt = plex_pkg::kw_text(k);
      narrowed_o[k] = mask_i[k] && in_slot && (txt[idx*8 +: 8] == c_i);
      endhit[k] = mask_i[k] && in_slot && (txt[idx*8 +: 8] == 8'd0);
    end
    kind_o = plex_pkg::K_IDENT;
    for (int k = KC - 1; k >= 0; k--) begin
      if (endhit[k]) kind_o = 6'(k);
    end
  end

endmodule

FILE: tb/sv/pseudocode_lexer_test.sv
`timescale 1ns / 1ps

module pseudocode_lexer_test;

  localparam int RUN_LIMIT = 400000;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END = 1'b1;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  plex_pkg::in_item_t in_data;
  plex_pkg::out_item_t out_data;

  pseudocode_lexer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  string keywords[32] = '{
    "debfonc", "finfonc", "faire", "finfaire", "si", "alors", "sinon", "finsi",
    "tantque", "pour", "haut", "bas", "et", "ou", "non", "div",
    "mod", "retourner", "structure", "type", "vide", "chaine", "caractere", "entier",
    "reel", "booleen", "vrai", "faux", "nil", "d", "r", "dr"};
  string operators[20] = '{"<=", "<-", "<", ">=", ">", "!=", "!", "->", "-", "+",
    "*", "/", "=", ".", ",", ";", "(", ")", "[", "]"};

  // lexer state mirror
  plex_pkg::mode_t mode;
  logic [15:0] line_cnt, col_cnt, pos_cnt;
  logic [15:0] tk_line, tk_col, tk_start, tk_len;
  logic [31:0] kw_cand;
  logic [7:0]  held;

  plex_pkg::out_item_t tokens_due[$];
  int        step_tokens;
  int        err_count = 0;
  int        cycle_count = 0;
  int        sent_count = 0;
  bit        no_idle = 0;
  int        stall_left = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] kw_char(int k, int i);
    string s;
    s = keywords[k];
    return (i < s.len()) ? s[i] : 8'd0;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] sym_kind(logic [7:0] c);
    case (c)
      "+": return plex_pkg::K_PLUS;
      "*": return plex_pkg::K_STAR;
      "/": return plex_pkg::K_SLASH;
      "=": return plex_pkg::K_EQ;
      ".": return plex_pkg::K_DOT;
      ",": return plex_pkg::K_COMMA;
      ";": return plex_pkg::K_SEMI;
      "(": return plex_pkg::K_LPAR;
      ")": return plex_pkg::K_RPAR;
      "[": return plex_pkg::K_LBRK;
      "]": return plex_pkg::K_RBRK;
      default: return plex_pkg::K_ERR_UNX;
    endcase
  endfunction

  function void advance(logic [7:0] c);
    pos_cnt = sat_inc(pos_cnt);
    if (c == 8'h0A) begin
      line_cnt = sat_inc(line_cnt);
      col_cnt = 16'd1;
    end else begin
      col_cnt = sat_inc(col_cnt);
    end
  endfunction

  function void add_token(logic [5:0] kind, logic [15:0] ln, logic [15:0] col,
                          logic [15:0] st, logic [15:0] len, logic [7:0] lit);
    plex_pkg::out_item_t t;
    t.token_kind = kind;
    t.token_line = ln;
    t.token_column = col;
    t.token_start = st;
    t.token_length = len;
    t.literal_char = lit;
    t.last_of_run = 1'b0;
    tokens_due.push_back(t);
    step_tokens++;
  endfunction

  function void narrow(logic [7:0] c);
    for (int k = 0; k < plex_pkg::KEYWORD_COUNT; k++)
      if (!(tk_len < plex_pkg::KW_SLOT && kw_char(k, int'(tk_len)) == c))
        kw_cand[k] = 1'b0;
  endfunction

  function automatic logic [5:0] word_kind();
    for (int k = 0; k < plex_pkg::KEYWORD_COUNT; k++)
      if (kw_cand[k] && tk_len < plex_pkg::KW_SLOT && kw_char(k, int'(tk_len)) == 8'd0)
        return 6'(k);
    return plex_pkg::K_IDENT;
  endfunction

  function void start_token();
    tk_line = line_cnt;
    tk_col = col_cnt;
    tk_start = pos_cnt;
    tk_len = 16'd0;
  endfunction

  function void scan_fresh(logic [7:0] c, bit fin);
    if (fin) begin
      add_token(plex_pkg::K_EOF, line_cnt, col_cnt, pos_cnt, 16'd0, 8'd0);
      return;
    end
    if (is_space(c)) begin
      advance(c);
      return;
    end
    start_token();
    if (is_alpha(c) || c == "_") begin
      kw_cand = '1;
      narrow(c);
      tk_len = 16'd1;
      mode = plex_pkg::M_IDENT;
    end else if (is_digit(c)) begin
      tk_len = 16'd1;
      mode = plex_pkg::M_NUMBER;
    end else if (c == 8'h22 || c == 8'h27) begin
      advance(c);
      tk_start = pos_cnt;
      mode = (c == 8'h22) ? plex_pkg::M_STRING : plex_pkg::M_CHVAL;
      return;
    end else if (c == "<") mode = plex_pkg::M_LESS;
    else if (c == ">") mode = plex_pkg::M_GREATER;
    else if (c == "!") mode = plex_pkg::M_BANG;
    else if (c == "-") mode = plex_pkg::M_MINUS;
    else add_token(sym_kind(c), line_cnt, col_cnt, pos_cnt, 16'd1, 8'd0);
    advance(c);
  endfunction

  function bit scan_pair(logic [7:0] c, bit fin, logic [7:0] second, logic [5:0] both,
                         logic [5:0] single);
    mode = plex_pkg::M_IDLE;
    if (!fin && c == second) begin
      add_token(both, tk_line, tk_col, tk_start, 16'd2, 8'd0);
      advance(c);
      return 1;
    end
    add_token(single, tk_line, tk_col, tk_start, 16'd1, 8'd0);
    return 0;
  endfunction

  function void predict_tokens(plex_pkg::in_item_t it);
    logic [7:0] c;
    bit fin, used;
    c = it.char_byte;
    fin = it.action || c == 8'd0;
    used = 0;
    step_tokens = 0;
    case (mode)
      plex_pkg::M_IDENT: begin
        if (!fin && (is_alpha(c) || is_digit(c) || c == "_")) begin
          narrow(c);
          tk_len = sat_inc(tk_len);
          advance(c);
          used = 1;
        end else begin
          add_token(word_kind(), tk_line, tk_col, tk_start, tk_len, 8'd0);
          mode = plex_pkg::M_IDLE;
        end
      end
      plex_pkg::M_NUMBER: begin
        if (!fin && is_digit(c)) begin
          tk_len = sat_inc(tk_len);
          advance(c);
          used = 1;
        end else begin
          add_token(plex_pkg::K_NUMBER, tk_line, tk_col, tk_start, tk_len, 8'd0);
          mode = plex_pkg::M_IDLE;
        end
      end
      plex_pkg::M_STRING: begin
        if (fin) begin
          add_token(plex_pkg::K_ERR_STR, tk_line, tk_col, tk_start, tk_len, 8'd0);
          mode = plex_pkg::M_IDLE;
        end else if (c == 8'h22) begin
          add_token(plex_pkg::K_STRING, tk_line, tk_col, tk_start, tk_len, 8'd0);
          advance(c);
          mode = plex_pkg::M_IDLE;
          used = 1;
        end else begin
          tk_len = sat_inc(tk_len);
          advance(c);
          used = 1;
        end
      end
      plex_pkg::M_CHVAL: begin
        if (fin) begin
          add_token(plex_pkg::K_ERR_CHR, tk_line, tk_col, tk_start, 16'd0, 8'd0);
          mode = plex_pkg::M_IDLE;
        end else begin
          held = c;
          advance(c);
          mode = plex_pkg::M_CHCLOSE;
          used = 1;
        end
      end
      plex_pkg::M_CHCLOSE: begin
        if (!fin && c == 8'h27) begin
          add_token(plex_pkg::K_CHARLIT, tk_line, tk_col, tk_start, 16'd1, held);
          advance(c);
          used = 1;
        end else begin
          add_token(plex_pkg::K_ERR_CHR, tk_line, tk_col, tk_start, 16'd1, 8'd0);
        end
        mode = plex_pkg::M_IDLE;
      end
      plex_pkg::M_LESS: begin
        if (!fin && c == "-") begin
          add_token(plex_pkg::K_ASSIGN, tk_line, tk_col, tk_start, 16'd2, 8'd0);
          advance(c);
          mode = plex_pkg::M_IDLE;
          used = 1;
        end else used = scan_pair(c, fin, "=", plex_pkg::K_LE, plex_pkg::K_LT);
      end
      plex_pkg::M_GREATER: used = scan_pair(c, fin, "=", plex_pkg::K_GE, plex_pkg::K_GT);
      plex_pkg::M_BANG:    used = scan_pair(c, fin, "=", plex_pkg::K_NE, plex_pkg::K_BANG);
      plex_pkg::M_MINUS:
        used = scan_pair(c, fin, ">", plex_pkg::K_ARROW, plex_pkg::K_MINUS);
      default:   mode = plex_pkg::M_IDLE;
    endcase
    if (!used) scan_fresh(c, fin);
    if (step_tokens > 0) tokens_due[$].last_of_run = 1'b1;
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  task check_token(plex_pkg::out_item_t got);
    plex_pkg::out_item_t want;
    if (tokens_due.size() == 0) begin
      report("unexpected token kind", 32'(got.token_kind), 32'd0);
      return;
    end
    want = tokens_due.pop_front();
    if (got.token_kind !== want.token_kind)
      report("kind", 32'(got.token_kind), 32'(want.token_kind));
    if (got.token_line !== want.token_line)
      report("line", 32'(got.token_line), 32'(want.token_line));
    if (got.token_column !== want.token_column)
      report("column", 32'(got.token_column), 32'(want.token_column));
    if (got.token_start !== want.token_start)
      report("start", 32'(got.token_start), 32'(want.token_start));
    if (got.token_length !== want.token_length)
      report("length", 32'(got.token_length), 32'(want.token_length));
    if (got.literal_char !== want.literal_char)
      report("literal", 32'(got.literal_char), 32'(want.literal_char));
    if (got.last_of_run !== want.last_of_run)
      report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
  endtask

  initial begin
    mode = plex_pkg::M_IDLE;
    line_cnt = 16'd1; col_cnt = 16'd1; pos_cnt = 16'd0;
    tk_line = 16'd1; tk_col = 16'd1; tk_start = 16'd0; tk_len = 16'd0;
    kw_cand = '1;
    held = 8'd0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_ready) predict_tokens(in_data);
      if (out_valid && out_ready) check_token(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  task send_item(logic act, logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.action = act;
    in_data.char_byte = c;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_BYTE, s[i]);
  endtask

  task send_end();
    send_item(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  task test_operators_and_words();
    send_text("si<=x_9\n");
    send_text("<->=>!=!->-+*/=.,;()[]");
    send_end();
  endtask

  task test_literals();
    send_text("42\"ab\"'q' ");
    send_item(ACT_BYTE, 8'h00);
  endtask

  task test_errors();
    send_text("\"ab");
    send_end();
    send_text("'");
    send_end();
    send_text("'xy@");
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, 8'h80);
    send_text("dr");
    send_end();
  endtask

  task send_lexeme();
    int kind, n;
    kind = $urandom_range(0, 99);
    if (kind < 22) send_text(keywords[$urandom_range(0, 31)]);
    else if (kind < 36) begin
      n = $urandom_range(1, 7);
      send_item(ACT_BYTE, ($urandom_range(0, 9) == 0) ? "_" : 8'("a" + $urandom_range(0, 25)));
      for (int i = 1; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: send_item(ACT_BYTE, 8'("0" + $urandom_range(0, 9)));
          1: send_item(ACT_BYTE, 8'("A" + $urandom_range(0, 25)));
          2: send_item(ACT_BYTE, "_");
          default: send_item(ACT_BYTE, 8'("a" + $urandom_range(0, 25)));
        endcase
      end
    end else if (kind < 46) begin
      n = $urandom_range(1, 6);
      repeat (n) send_item(ACT_BYTE, 8'("0" + $urandom_range(0, 9)));
    end else if (kind < 54) begin
      send_item(ACT_BYTE, 8'h22);
      n = $urandom_range(0, 6);
      repeat (n) send_item(ACT_BYTE, 8'($urandom_range(1, 255)) == 8'h22 ? "z"
                                      : 8'($urandom_range(1, 255)));
      send_item(ACT_BYTE, 8'h22);
    end else if (kind < 62) begin
      send_item(ACT_BYTE, 8'h27);
      send_item(ACT_BYTE, 8'($urandom_range(1, 255)));
      send_item(ACT_BYTE, 8'h27);
    end else if (kind < 82) send_text(operators[$urandom_range(0, 19)]);
    else if (kind < 92) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    else if (kind < 96) begin
      send_item(ACT_BYTE, ($urandom_range(0, 1) == 0) ? 8'h27 : 8'h22);
      repeat ($urandom_range(0, 2)) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    end else send_end();
    case ($urandom_range(0, 5))
      0, 1: send_item(ACT_BYTE, " ");
      2: send_item(ACT_BYTE, 8'h0A);
      3: send_item(ACT_BYTE, 8'($urandom_range(9, 13)));
      default: ;
    endcase
  endtask

  task test_random_source(int items);
    int stop_at;
    stop_at = sent_count + items;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      send_lexeme();
    end
    no_idle = 0;
    send_end();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_operators_and_words();
    test_literals();
    test_errors();
    test_random_source(1250);
    in_valid = 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/plex_pkg.sv
rtl/core/plex_kwmatch.sv
rtl/core/pseudocode_lexer.sv
tb/sv/pseudocode_lexer_test.sv
